[design/panel_spi_register_access_assert.svh]
// Assertion macros for the panel SPI register access block.
// Included by the top level; no other dependencies.
`ifndef PANEL_SPI_REGISTER_ACCESS_ASSERT_SVH
`define PANEL_SPI_REGISTER_ACCESS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PSRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/psra_pkg.sv]
// Shared types and constants for the panel SPI register access block.
// No dependencies.
`timescale 1ns / 1ps

package psra_pkg;

	localparam logic [7:0] START_INDEX = 8'h70;
	localparam logic [7:0] START_WRITE = 8'h72;
	localparam logic [7:0] START_READ  = 8'h73;
	localparam logic [5:0] FRAME_BITS      = 6'd24;
	localparam logic [5:0] READ_FRAME_BITS = 6'd32;
	localparam logic [4:0] START_BYTE_BITS = 5'd8;
	localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	typedef enum logic [1:0] {
		STEP_IDLE   = 2'd0,
		STEP_FIRST  = 2'd1,
		STEP_GAP    = 2'd2,
		STEP_SECOND = 2'd3
	} step_t;

	// Classified tick as passed from front to back
	typedef struct packed {
		logic        start;
		logic        is_read;
		logic [23:0] first_word;
		logic [15:0] value;
		logic        sdi;
	} tick_t;

	typedef struct packed {
		logic        cs_n;
		logic        sclk;
		logic        sdo;
		logic        busy;
		logic [15:0] read_value;
		logic        read_done;
		logic        rejected;
	} result_t;

endpackage

[design/panel_spi_register_access.sv]
// A tick is stored in the tick queue; its pin levels are stored in the result queue.
// Throughput: one tick per cycle while neither queue stalls; the serial engine advances one tick per beat.
// Input and result queues stall independently; each holds QUEUE_DEPTH beats.
// Reset: queues empty, engine idle (cs_n, sclk, sdo high), half period back to 4 ticks.
// Depends on psra_pkg, psra_front, psra_fifo, psra_back and the assertion header.
`timescale 1ns / 1ps

`include "panel_spi_register_access_assert.svh"

module panel_spi_register_access #(
	parameter int unsigned QUEUE_DEPTH = psra_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [15:0] reg_index,
	input  logic [15:0] reg_value,
	input  logic        sdi_bit,
	output logic        empty,
	input  logic        pop,
	output logic        cs_n,
	output logic        sclk,
	output logic        sdo,
	output logic        busy_res,
	output logic [15:0] read_value,
	output logic        read_done,
	output logic        req_rejected
);

	localparam int unsigned TW = $bits(psra_pkg::tick_t);
	localparam int unsigned RW = $bits(psra_pkg::result_t);

	logic [7:0]        half_q;
	logic              mid_full;
	logic              mid_push;
	logic              mid_empty;
	logic              mid_pop;
	psra_pkg::tick_t   front_tick;
	psra_pkg::tick_t   back_tick;
	logic              res_full;
	logic              res_push;
	psra_pkg::result_t back_res;
	psra_pkg::result_t head_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= psra_pkg::HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	psra_front u_front (
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.reg_index (reg_index),
		.reg_value (reg_value),
		.sdi_bit   (sdi_bit),
		.q_full    (mid_full),
		.q_push    (mid_push),
		.q_tick    (front_tick)
	);

	psra_fifo #(
		.WIDTH (TW),
		.DEPTH (QUEUE_DEPTH)
	) u_tick_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (front_tick),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (back_tick),
		.empty  (mid_empty)
	);

	psra_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.half_period (half_q),
		.in_empty    (mid_empty),
		.in_tick     (back_tick),
		.in_pop      (mid_pop),
		.out_full    (res_full),
		.out_push    (res_push),
		.out_res     (back_res)
	);

	psra_fifo #(
		.WIDTH (RW),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (head_res),
		.empty  (empty)
	);

	assign cs_n         = head_res.cs_n;
	assign sclk         = head_res.sclk;
	assign sdo          = head_res.sdo;
	assign busy_res     = head_res.busy;
	assign read_value   = head_res.read_value;
	assign read_done    = head_res.read_done;
	assign req_rejected = head_res.rejected;

	// A finished read ends the access with the bus released
	`PSRA_ASSERT_IMP(a_done_idle, clk, arst_n, !empty && read_done, !busy_res && cs_n && sclk, "read done while bus active")
	// Idle engine leaves every pin at its idle level
	`PSRA_ASSERT_IMP(a_idle_pins, clk, arst_n, !empty && !busy_res, cs_n && sclk && sdo, "idle pins not high")
	// Read data only shows on the completion beat
	`PSRA_ASSERT_IMP(a_value_done, clk, arst_n, !empty && (read_value != 16'h0000), read_done, "read value without done")
	// Back end never pushes into a full result queue
	`PSRA_ASSERT_NXT(a_res_q_room, clk, arst_n, res_full && !pop, res_full, "result queue lost a beat")

endmodule

[design/psra_fifo.sv]
// Small register queue used between the front, the back and the result side.
// Depends on nothing; DEPTH must be at least 2.
`timescale 1ns / 1ps

module psra_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[design/psra_front.sv]
// Front end: takes ticks, decodes the request code and builds the first frame.
// Depends on psra_pkg.
`timescale 1ns / 1ps

module psra_front (
	input  logic             push,
	output logic             full,
	input  logic [1:0]       req_type,
	input  logic [15:0]      reg_index,
	input  logic [15:0]      reg_value,
	input  logic             sdi_bit,
	input  logic             q_full,
	output logic             q_push,
	output psra_pkg::tick_t  q_tick
);

	assign full   = q_full;
	assign q_push = push;

	// Code 3 is a plain tick
	always_comb begin
		q_tick.start      = (req_type == psra_pkg::REQ_WRITE) ||
		                    (req_type == psra_pkg::REQ_READ);
		q_tick.is_read    = (req_type == psra_pkg::REQ_READ);
		q_tick.first_word = {psra_pkg::START_INDEX, reg_index};
		q_tick.value      = reg_value;
		q_tick.sdi        = sdi_bit;
	end

endmodule

[design/psra_back.sv]
// Back end: serial engine that advances one tick per beat and emits pin levels.
// Depends on psra_pkg.
`timescale 1ns / 1ps

module psra_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        half_period,
	input  logic              in_empty,
	input  psra_pkg::tick_t   in_tick,
	output logic              in_pop,
	input  logic              out_full,
	output logic              out_push,
	output psra_pkg::result_t out_res
);

	logic            fire;
	logic [7:0]      div_q,    div_n;
	logic            phase_q,  phase_n;
	logic [4:0]      bit_q,    bit_n;
	psra_pkg::step_t step_q,   step_n;
	logic [23:0]     sout_q,   sout_n;
	logic [23:0]     sin_q,    sin_n;
	logic            rd_q,     rd_n;
	logic [15:0]     held_q,   held_n;
	logic            active_q, active_n;
	logic            rejected;
	logic            done;
	logic            div_end;
	logic [5:0]      frame_len;
	logic            last_bit;
	logic            in_frame;

	assign fire     = !in_empty && !out_full;
	assign in_pop   = fire;
	assign out_push = fire;

	// A zero divider behaves like one
	assign div_end   = ({1'b0, div_q} + 9'd1) >= {1'b0, half_period};
	assign frame_len = (step_q == psra_pkg::STEP_SECOND && rd_q) ?
	                   psra_pkg::READ_FRAME_BITS : psra_pkg::FRAME_BITS;
	assign last_bit  = ({1'b0, bit_q} + 6'd1) >= frame_len;

	always_comb begin
		div_n    = div_q;
		phase_n  = phase_q;
		bit_n    = bit_q;
		step_n   = step_q;
		sout_n   = sout_q;
		sin_n    = sin_q;
		rd_n     = rd_q;
		held_n   = held_q;
		active_n = active_q;
		rejected = 1'b0;
		done     = 1'b0;
		if (active_q) begin
			rejected = in_tick.start;
			if (div_end) begin
				div_n = '0;
				priority if (step_q == psra_pkg::STEP_GAP) begin
					step_n  = psra_pkg::STEP_SECOND;
					bit_n   = '0;
					phase_n = 1'b0;
					sout_n  = rd_q ? {psra_pkg::START_READ, 16'h0000}
					               : {psra_pkg::START_WRITE, held_q};
				end else if (!phase_q) begin
					// rising edge: sample after the start byte of a read
					phase_n = 1'b1;
					if (step_q == psra_pkg::STEP_SECOND && rd_q &&
					    bit_q >= psra_pkg::START_BYTE_BITS) begin
						sin_n = {sin_q[22:0], in_tick.sdi};
					end
				end else begin
					sout_n = {sout_q[22:0], 1'b0};
					if (last_bit) begin
						bit_n   = '0;
						phase_n = 1'b1;
						if (step_q == psra_pkg::STEP_FIRST) begin
							step_n = psra_pkg::STEP_GAP;
						end else begin
							step_n   = psra_pkg::STEP_IDLE;
							active_n = 1'b0;
							done     = rd_q;
						end
					end else begin
						bit_n   = bit_q + 5'd1;
						phase_n = 1'b0;
					end
				end
			end else begin
				div_n = div_q + 8'd1;
			end
		end else if (in_tick.start) begin
			active_n = 1'b1;
			rd_n     = in_tick.is_read;
			held_n   = in_tick.value;
			sout_n   = in_tick.first_word;
			sin_n    = '0;
			step_n   = psra_pkg::STEP_FIRST;
			bit_n    = '0;
			phase_n  = 1'b0;
			div_n    = '0;
		end
	end

	// Pin levels follow the state after this tick
	always_comb begin
		in_frame             = (step_n == psra_pkg::STEP_FIRST) ||
		                       (step_n == psra_pkg::STEP_SECOND);
		out_res.cs_n         = !in_frame;
		out_res.sclk         = in_frame ? phase_n : 1'b1;
		out_res.sdo          = in_frame ? sout_n[23] : 1'b1;
		out_res.busy         = active_n;
		out_res.read_value   = done ? {sin_q[23:16], sin_q[7:0]} : 16'h0000;
		out_res.read_done    = done;
		out_res.rejected     = rejected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q    <= '0;
			phase_q  <= 1'b1;
			bit_q    <= '0;
			step_q   <= psra_pkg::STEP_IDLE;
			sout_q   <= '0;
			sin_q    <= '0;
			rd_q     <= 1'b0;
			held_q   <= '0;
			active_q <= 1'b0;
		end else if (fire) begin
			div_q    <= div_n;
			phase_q  <= phase_n;
			bit_q    <= bit_n;
			step_q   <= step_n;
			sout_q   <= sout_n;
			sin_q    <= sin_n;
			rd_q     <= rd_n;
			held_q   <= held_n;
			active_q <= active_n;
		end
	end

endmodule

[test/panel_spi_register_access_checker.sv]
// Checker for the panel SPI register access block: tracks the half-period register,
// predicts the pin levels of every accepted tick and compares each popped result beat.
// Depends on psra_pkg.
`timescale 1ns / 1ps

module panel_spi_register_access_checker
	import psra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  req_type,
	input  logic [15:0] reg_index,
	input  logic [15:0] reg_value,
	input  logic        sdi_bit,
	input  logic        empty,
	input  logic        pop,
	input  logic        cs_n,
	input  logic        sclk,
	input  logic        sdo,
	input  logic        busy_res,
	input  logic [15:0] read_value,
	input  logic        read_done,
	input  logic        req_rejected,
	output int          errors,
	output int          waiting
);

	// serial engine state
	logic [7:0]  half_ticks;
	logic [7:0]  div_cnt;
	logic        clk_high;
	logic [4:0]  bit_cnt;
	step_t       step;
	logic [23:0] out_sr;
	logic [23:0] in_sr;
	logic        read_op;
	logic [15:0] held;
	logic        engaged;

	result_t     pin_levels_q[$];

	task automatic clear_engine();
		half_ticks = HALF_PERIOD_RESET;
		div_cnt = '0;
		clk_high = 1'b1;
		bit_cnt = '0;
		step = STEP_IDLE;
		out_sr = '0;
		in_sr = '0;
		read_op = 1'b0;
		held = '0;
		engaged = 1'b0;
	endtask

	// Advance the engine by one tick and return the pin levels after it.
	task automatic step_engine(input logic [1:0] req, input logic [15:0] idx,
			input logic [15:0] val, input logic sdi, output result_t lv);
		logic        starting;
		logic        in_frame;
		int          len;
		logic [15:0] word;
		starting = (req == REQ_WRITE) || (req == REQ_READ);
		lv = '0;
		if (engaged) begin
			lv.rejected = starting;
			// a zero divider compares like one
			if (int'(div_cnt) + 1 >= int'(half_ticks)) begin
				div_cnt = '0;
				if (step == STEP_GAP) begin
					step = STEP_SECOND;
					bit_cnt = '0;
					clk_high = 1'b0;
					out_sr = read_op ? {START_READ, 16'h0000} : {START_WRITE, held};
				end else if (!clk_high) begin
					clk_high = 1'b1;
					// read frame: start byte first, then 24 sampled bits
					if (step == STEP_SECOND && read_op && bit_cnt >= START_BYTE_BITS)
						in_sr = {in_sr[22:0], sdi};
				end else begin
					len = (step == STEP_SECOND && read_op) ? int'(READ_FRAME_BITS)
						: int'(FRAME_BITS);
					out_sr = {out_sr[22:0], 1'b0};
					if (int'(bit_cnt) + 1 >= len) begin
						bit_cnt = '0;
						clk_high = 1'b1;
						if (step == STEP_FIRST) begin
							step = STEP_GAP;
						end else begin
							step = STEP_IDLE;
							engaged = 1'b0;
							if (read_op) begin
								word = {in_sr[23:16], in_sr[7:0]};
								held = word;
								lv.read_value = word;
								lv.read_done = 1'b1;
							end
						end
					end else begin
						bit_cnt = bit_cnt + 5'd1;
						clk_high = 1'b0;
					end
				end
			end else begin
				div_cnt = div_cnt + 8'd1;
			end
		end else if (starting) begin
			engaged = 1'b1;
			read_op = (req == REQ_READ);
			held = val;
			out_sr = {START_INDEX, idx};
			in_sr = '0;
			step = STEP_FIRST;
			bit_cnt = '0;
			clk_high = 1'b0;
			div_cnt = '0;
		end
		in_frame = (step == STEP_FIRST) || (step == STEP_SECOND);
		lv.cs_n = !in_frame;
		lv.sclk = in_frame ? clk_high : 1'b1;
		lv.sdo = in_frame ? out_sr[23] : 1'b1;
		lv.busy = engaged;
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t lv;
		result_t want;
		if (!arst_n) begin
			clear_engine();
			pin_levels_q.delete();
		end else begin
			if (cfg_we)
				half_ticks = cfg_wdata;
			// pop before push so a beat never matches the tick accepted on the same edge
			if (pop && !empty) begin
				if (pin_levels_q.size() == 0) begin
					report_mismatch("result beat with no tick waiting for it");
				end else begin
					want = pin_levels_q.pop_front();
					check_field("cs_n", cs_n, want.cs_n);
					check_field("sclk", sclk, want.sclk);
					check_field("sdo", sdo, want.sdo);
					check_field("busy_res", busy_res, want.busy);
					check_field("read_value", read_value, want.read_value);
					check_field("read_done", read_done, want.read_done);
					check_field("req_rejected", req_rejected, want.rejected);
				end
			end
			if (push && !full) begin
				step_engine(req_type, reg_index, reg_value, sdi_bit, lv);
				pin_levels_q.push_back(lv);
			end
		end
		waiting = pin_levels_q.size();
	end

endmodule

[test/panel_spi_register_access_test.sv]
// Top of the panel SPI register access testbench: clock, reset, tick and config stimulus,
// random stalls on both queues and the final verdict.
// Depends on psra_pkg, the block and panel_spi_register_access_checker.
`timescale 1ns / 1ps

module panel_spi_register_access_test;
	import psra_pkg::*;

	typedef enum int {SDI_RANDOM, SDI_ZEROS, SDI_ONES} sdi_mode_t;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// half periods from the start tick to the last busy tick
	localparam int WRITE_HALVES = 97;
	localparam int READ_HALVES  = 113;
	localparam int RANDOM_TICKS = 300;
	localparam int PHASES       = 3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  req_type = REQ_TICK;
	logic [15:0] reg_index = '0;
	logic [15:0] reg_value = '0;
	logic        sdi_bit = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        cs_n;
	logic        sclk;
	logic        sdo;
	logic        busy_res;
	logic [15:0] read_value;
	logic        read_done;
	logic        req_rejected;
	int          errors;
	int          waiting;

	bit          calm = 1'b0;
	int          push_idle_pct = 0;
	int          half_eff = HALF_PERIOD_RESET;
	int          busy_left = 0;
	int          sent = 0;
	sdi_mode_t   sdi_mode = SDI_RANDOM;

	panel_spi_register_access dut (.*);

	panel_spi_register_access_checker chk (.*);

	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: runs of pop with idle bursts between them, except in the calm phase
	initial begin : drain
		int n;
		forever begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 24);
			repeat (n) begin
				@(negedge clk);
				pop <= 1'b1;
			end
			if (!calm) begin
				n = $urandom_range(1, 16);
				repeat (n) begin
					@(negedge clk);
					pop <= 1'b0;
				end
			end
		end
	end

	// One tick beat; also tracks how long the engine stays busy.
	task automatic send_tick(input logic [1:0] req, input logic [15:0] idx,
			input logic [15:0] val);
		int gap;
		if (!calm && $urandom_range(1, 100) <= push_idle_pct) begin
			gap = $urandom_range(1, 16);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
		end
		@(negedge clk);
		push <= 1'b1;
		req_type <= req;
		reg_index <= idx;
		reg_value <= val;
		sdi_bit <= (sdi_mode == SDI_RANDOM) ? 1'($urandom_range(0, 1)) : (sdi_mode == SDI_ONES);
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
		if (busy_left > 0)
			busy_left--;
		else if (req == REQ_WRITE || req == REQ_READ)
			busy_left = half_eff * ((req == REQ_READ) ? READ_HALVES : WRITE_HALVES);
	endtask

	task automatic plain_tick();
		send_tick(REQ_TICK, 16'($urandom), 16'($urandom));
	endtask

	// Wait out any access, start one, and run it to its end. A random write, read or unused
	// code lands on the tick where clash_at ticks are left (1 is the final tick, 0 never).
	task automatic run_access(input logic [1:0] req, input logic [15:0] idx,
			input logic [15:0] val, input int clash_at);
		while (busy_left > 0)
			plain_tick();
		send_tick(req, idx, val);
		while (busy_left > 0) begin
			if (busy_left == clash_at)
				send_tick(2'($urandom_range(REQ_WRITE, REQ_UNUSED)), 16'($urandom),
					16'($urandom));
			else
				plain_tick();
		end
	endtask

	task automatic settle();
		while (busy_left > 0)
			plain_tick();
		@(negedge clk);
		push <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_half_period(input logic [7:0] h);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		half_eff = (h == 0) ? 1 : h;
	endtask

	initial begin
		logic [7:0] phase_half[PHASES];
		int         phase_end;
		int         n;
		phase_half = '{8'd2, 8'd0, 8'd1};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset divider, extremes, rejected requests, divider 0
		push_idle_pct = 10;
		send_tick(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
		sdi_mode = SDI_ONES;
		run_access(REQ_WRITE, 16'hFFFF, 16'h0000, 1);
		set_half_period(8'd1);
		sdi_mode = SDI_ZEROS;
		run_access(REQ_READ, 16'h0000, 16'hFFFF, 1);
		sdi_mode = SDI_RANDOM;
		send_tick(REQ_UNUSED, 16'h0000, 16'h0000);
		run_access(REQ_WRITE, 16'h5A3C, 16'hA5C3, 30);
		set_half_period(8'd0);
		run_access(REQ_WRITE, 16'h1234, 16'hEDCB, 1);

		// random accesses over several divider settings; the last phase runs without idling
		sent = 0;
		for (int p = 0; p < PHASES; p++) begin
			set_half_period(phase_half[p]);
			calm = (p == PHASES - 1);
			push_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
			phase_end = sent + RANDOM_TICKS / PHASES;
			while (sent < phase_end) begin
				n = $urandom_range(0, 9);
				if (n < 7) begin
					sdi_mode = ($urandom_range(0, 3) == 0) ?
						sdi_mode_t'($urandom_range(SDI_ZEROS, SDI_ONES)) : SDI_RANDOM;
					case ($urandom_range(0, 3))
						0: n = 1;
						1: n = $urandom_range(1, half_eff * READ_HALVES);
						default: n = 0;
					endcase
					run_access($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, 16'($urandom),
						16'($urandom), n);
				end else if (n < 9) begin
					sdi_mode = SDI_RANDOM;
					repeat ($urandom_range(1, 6))
						send_tick(2'($urandom), 16'($urandom), 16'($urandom));
				end else begin
					repeat ($urandom_range(1, 10))
						plain_tick();
				end
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/psra_pkg.sv
design/psra_fifo.sv
design/psra_front.sv
design/psra_back.sv
design/panel_spi_register_access.sv
test/panel_spi_register_access_checker.sv
test/panel_spi_register_access_test.sv
